// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the sensor compensation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define ASSERT_DELAY(lbl, clk, rst_n, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/esc_pkg.sv =====
// Types and constants of the sensor compensation block.
`timescale 1ns / 1ps
`default_nettype none
package esc_pkg;

	localparam int APB_AW = 6;
	localparam int APB_DW = 64;
	localparam int COEF_W = 48;
	localparam int NUM_REGS = 6;

	localparam logic [2:0] REG_TEMP    = 3'd0;
	localparam logic [2:0] REG_PRESS_A = 3'd1;
	localparam logic [2:0] REG_PRESS_B = 3'd2;
	localparam logic [2:0] REG_PRESS_C = 3'd3;
	localparam logic [2:0] REG_HUM_A   = 3'd4;
	localparam logic [2:0] REG_HUM_B   = 3'd5;

	localparam int MUL_W = 64;
	localparam int MUL_HALF = MUL_W / 2;

	localparam int PIPE_LAT = 67;

	localparam logic signed [14:0] TEMP_MIN = -15'sd4000;
	localparam logic signed [14:0] TEMP_MAX = 15'sd8500;
	localparam logic [24:0] P_MIN = 25'd7680000;
	localparam logic [24:0] P_MAX = 25'd28160000;
	localparam logic [26:0] H_MAX = 27'd104857600;
	localparam logic [16:0] HUM_MAX = 17'd102400;
	localparam logic [45:0] Q_LIM = 46'd17592186044416;

	typedef struct packed {
		logic [19:0] pressure_sample;
		logic [19:0] temperature_sample;
		logic [15:0] humidity_sample;
	} sample_t;

	typedef struct packed {
		logic signed [14:0] temperature_centi;
		logic [24:0]        pressure_q8;
		logic [16:0]        humidity_q10;
		logic signed [31:0] fine_temperature;
		logic               pressure_invalid;
	} result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/esc_mul.sv =====
// Two-stage signed 64 by 64 multiplier built from four half-width partial products.
`timescale 1ns / 1ps
`default_nettype none
module esc_mul (
	input  logic                               clk,
	input  logic signed [esc_pkg::MUL_W-1:0]   a,
	input  logic signed [esc_pkg::MUL_W-1:0]   b,
	output logic signed [2*esc_pkg::MUL_W-1:0] p
);
	import esc_pkg::*;

	logic [MUL_HALF-1:0]          al, bl;
	logic signed [MUL_HALF-1:0]   ah, bh;
	logic [MUL_W-1:0]             pll_s1;
	logic signed [MUL_W:0]        plh_s1, phl_s1;
	logic signed [MUL_W-1:0]      phh_s1;
	logic signed [2*MUL_W-1:0]    prod_s2;

	assign al = a[MUL_HALF-1:0];
	assign ah = a[MUL_W-1:MUL_HALF];
	assign bl = b[MUL_HALF-1:0];
	assign bh = b[MUL_W-1:MUL_HALF];

	// The low halves are unsigned, the high halves carry the sign.
	always_ff @(posedge clk) begin
		pll_s1  <= al * bl;
		plh_s1  <= $signed({1'b0, al}) * bh;
		phl_s1  <= ah * $signed({1'b0, bl});
		phh_s1  <= ah * bh;
		prod_s2 <= ((2*MUL_W)'(phh_s1) <<< MUL_W) + ((2*MUL_W)'(plh_s1) <<< MUL_HALF)
			+ ((2*MUL_W)'(phl_s1) <<< MUL_HALF) + $signed({{MUL_W{1'b0}}, pll_s1});
	end

	assign p = prod_s2;

endmodule
`default_nettype wire

// ===== hw/rtl/env_sensor_compensation.sv =====
// Top level of the environmental sensor compensation pipeline.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Usage:
// A raw triple is presented on sample with start high; it is taken at the
// rising edge where start is high and busy is low. busy is never raised, so a
// new transaction may be started in every cycle.
// Each result appears on result with result_valid high for exactly one cycle
// and results come out in sample order.
// The pipeline runs 67 register stages; the pressure division resolves one
// quotient bit per stage over 45 of them. Throughput is one transaction per
// cycle. The receiver cannot stall, so the pipeline never holds.
// The calibration registers sit on the APB port at byte address 8*index and
// reset to zero. The user must write them only while no transaction is in
// flight; the block itself does not enforce this.
// Reset clears all valid bits at once; samples in flight are dropped.
module env_sensor_compensation (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  esc_pkg::sample_t              sample,
	output logic                          result_valid,
	output esc_pkg::result_t              result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [esc_pkg::APB_AW-1:0]    paddr,
	input  logic [esc_pkg::APB_DW-1:0]    pwdata,
	output logic [esc_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);
	import esc_pkg::*;

	localparam int MUL_H6V5 = 0;
	localparam int MUL_V5V6 = 1;
	localparam int MUL_AM   = 2;
	localparam int MUL_HV   = 3;
	localparam int MUL_P6   = 4;
	localparam int MUL_P3   = 5;
	localparam int MUL_P1   = 6;
	localparam int MUL_Q9   = 7;
	localparam int NUM_MUL  = 8;

	// Configuration registers.
	logic [COEF_W-1:0] coef_q [NUM_REGS];
	logic [2:0]        reg_idx;

	// Coefficients.
	logic [15:0]        t1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
	logic signed [16:0] p1s;
	logic signed [8:0]  h1s, h3s;
	logic signed [11:0] h4, h5;
	logic signed [7:0]  h6;

	// Multipliers.
	logic signed [MUL_W-1:0]   mul_a [NUM_MUL];
	logic signed [MUL_W-1:0]   mul_b [NUM_MUL];
	logic signed [2*MUL_W-1:0] mul_p [NUM_MUL];

	// Valid bits.
	logic vld_s [1:PIPE_LAT];

	// Temperature path.
	logic [19:0]        rp_s [1:12];
	logic [15:0]        rh_s [1:7];
	logic signed [21:0] d_c, d_s1;
	logic signed [37:0] dt2_s2, dt2_s3;
	logic signed [43:0] dd_s2;
	logic signed [60:0] ddt3_s3;
	logic signed [59:0] s_c, s_s4;
	logic signed [25:0] fq_c, fine_c;
	logic               rnd_c;
	logic signed [20:0] c5_c;
	logic signed [14:0] centi_c;
	logic signed [14:0] temp_s [5:66];
	logic signed [25:0] fine_s [5:66];
	logic signed [25:0] x_s6, p_s6;

	// Humidity path.
	logic signed [37:0] h5x_s7;
	logic signed [33:0] h6x_s7, h6x_s8;
	logic signed [34:0] h3x_s7;
	logic signed [40:0] a_s8;
	logic signed [35:0] v5_s [8:11];
	logic signed [56:0] ah2_s [9:14];
	logic signed [44:0] v6_s11;
	logic signed [54:0] m_s14;
	logic signed [91:0] vr_c;
	logic signed [45:0] v_c;
	logic signed [45:0] v_s [17:20];
	logic signed [54:0] h1v_s18;
	logic signed [59:0] h_s21;
	logic [26:0]        hc_c;
	logic [16:0]        hq_c;
	logic [16:0]        hq_s [22:66];

	// Pressure path.
	logic signed [51:0] pp_s7;
	logic signed [41:0] p5_s [7:9];
	logic signed [41:0] p2_s [7:9];
	logic signed [57:0] g_s [10:12];
	logic signed [57:0] e_s10;
	logic [20:0]        nb_c;
	logic signed [43:0] dv_s13;
	logic signed [58:0] n_s13;
	logic [57:0]        absn_s14;
	logic [70:0]        num_s15;
	logic [42:0]        dv_s [14:60];
	logic               neg_s [14:61];
	logic               inv_s [14:66];
	logic               ovf_s [16:61];
	logic [42:0]        rem_s [16:61];
	logic [44:0]        low_s [16:61];
	logic [43:0]        trial [17:61];
	logic               fit [17:61];
	logic [45:0]        mag_c;
	logic signed [46:0] q_s [62:66];
	logic signed [62:0] qp9_s63;
	logic signed [62:0] qp8_s [63:65];
	logic signed [71:0] t_s66;
	logic signed [71:0] f_c;
	logic [24:0]        press_c;
	result_t            res_s67;

	// ---------------------------------------------------------------- APB
	assign pready  = 1'b1;
	assign busy    = 1'b0;
	assign reg_idx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) coef_q[i] <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_TEMP, REG_PRESS_A, REG_PRESS_B, REG_PRESS_C: begin
					coef_q[reg_idx] <= pwdata[COEF_W-1:0];
				end
				REG_HUM_A, REG_HUM_B: begin
					coef_q[reg_idx] <= {16'b0, pwdata[31:0]};
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TEMP, REG_PRESS_A, REG_PRESS_B, REG_PRESS_C, REG_HUM_A, REG_HUM_B: begin
				prdata = APB_DW'(coef_q[reg_idx]);
			end
			default: prdata = '0;
		endcase
	end

	assign t1  = coef_q[REG_TEMP][15:0];
	assign t2  = coef_q[REG_TEMP][31:16];
	assign t3  = coef_q[REG_TEMP][47:32];
	assign p1s = $signed({1'b0, coef_q[REG_PRESS_A][15:0]});
	assign p2  = coef_q[REG_PRESS_A][31:16];
	assign p3  = coef_q[REG_PRESS_A][47:32];
	assign p4  = coef_q[REG_PRESS_B][15:0];
	assign p5  = coef_q[REG_PRESS_B][31:16];
	assign p6  = coef_q[REG_PRESS_B][47:32];
	assign p7  = coef_q[REG_PRESS_C][15:0];
	assign p8  = coef_q[REG_PRESS_C][31:16];
	assign p9  = coef_q[REG_PRESS_C][47:32];
	assign h1s = $signed({1'b0, coef_q[REG_HUM_A][7:0]});
	assign h2  = coef_q[REG_HUM_A][23:8];
	assign h3s = $signed({1'b0, coef_q[REG_HUM_A][31:24]});
	assign h4  = coef_q[REG_HUM_B][11:0];
	assign h5  = coef_q[REG_HUM_B][23:12];
	assign h6  = coef_q[REG_HUM_B][31:24];

	// ---------------------------------------------------------------- multipliers
	assign mul_a[MUL_H6V5] = MUL_W'(h6x_s8);
	assign mul_b[MUL_H6V5] = MUL_W'(v5_s[8]);
	assign mul_a[MUL_V5V6] = MUL_W'(v5_s[11]);
	assign mul_b[MUL_V5V6] = MUL_W'(v6_s11);
	assign mul_a[MUL_AM]   = MUL_W'(ah2_s[14]);
	assign mul_b[MUL_AM]   = MUL_W'(m_s14);
	assign mul_a[MUL_HV]   = MUL_W'(h1v_s18);
	assign mul_b[MUL_HV]   = MUL_W'(v_s[18]);
	assign mul_a[MUL_P6]   = MUL_W'(pp_s7);
	assign mul_b[MUL_P6]   = MUL_W'(p6);
	assign mul_a[MUL_P3]   = MUL_W'(pp_s7);
	assign mul_b[MUL_P3]   = MUL_W'(p3);
	assign mul_a[MUL_P1]   = MUL_W'(p1s);
	assign mul_b[MUL_P1]   = MUL_W'(e_s10);
	assign mul_a[MUL_Q9]   = MUL_W'(qp9_s63);
	assign mul_b[MUL_Q9]   = MUL_W'(q_s[63]);

	for (genvar i = 0; i < NUM_MUL; i++) begin : g_mul
		esc_mul u_mul (
			.clk (clk),
			.a   (mul_a[i]),
			.b   (mul_b[i]),
			.p   (mul_p[i])
		);
	end

	// ---------------------------------------------------------------- datapath logic
	always_comb begin
		d_c = $signed({2'b00, sample.temperature_sample} - {2'b00, t1, 4'b0000});
		s_c = (60'(dt2_s3) <<< 20) + 60'(ddt3_s3);

		// Fine temperature truncates toward zero, the centidegree value rounds.
		fq_c   = 26'(s_s4 >>> 34);
		rnd_c  = s_s4[59] && (s_s4[33:0] != '0);
		fine_c = fq_c + 26'(rnd_c);
		c5_c   = 21'((63'(s_s4) * 63'sd5 + 63'sd2199023255552) >>> 42);
		if (c5_c < TEMP_MIN) begin
			centi_c = TEMP_MIN;
		end else if (c5_c > TEMP_MAX) begin
			centi_c = TEMP_MAX;
		end else begin
			centi_c = 15'(c5_c);
		end

		vr_c = 92'(mul_p[MUL_AM] >>> 36);
		if (vr_c > $signed({1'b0, Q_LIM})) begin
			v_c = $signed(Q_LIM);
		end else if (vr_c < -$signed({1'b0, Q_LIM})) begin
			v_c = -$signed(Q_LIM);
		end else begin
			v_c = 46'(vr_c);
		end

		if (h_s21 < 0) begin
			hc_c = '0;
		end else if (h_s21 > $signed({33'b0, H_MAX})) begin
			hc_c = H_MAX;
		end else begin
			hc_c = 27'(h_s21);
		end
		hq_c = 17'((28'(hc_c) + 28'd512) >> 10);

		nb_c = 21'd1048576 - {1'b0, rp_s[12]};

		// A negative quotient takes the floor, so a nonzero remainder adds one.
		mag_c = {1'b0, low_s[61]} + 46'(neg_s[61] && (rem_s[61] != '0));
		if (ovf_s[61] || (mag_c > Q_LIM)) mag_c = Q_LIM;

		f_c = 72'(q_s[66]) + (t_s66 >>> 4);
		if (inv_s[66]) begin
			press_c = P_MIN;
		end else if (f_c < $signed({47'b0, P_MIN})) begin
			press_c = P_MIN;
		end else if (f_c > $signed({47'b0, P_MAX})) begin
			press_c = P_MAX;
		end else begin
			press_c = 25'(f_c);
		end

		for (int k = 17; k <= 61; k++) begin
			trial[k] = {rem_s[k-1], low_s[k-1][44]};
			fit[k]   = trial[k] >= {1'b0, dv_s[k-1]};
		end
	end

	// ---------------------------------------------------------------- valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= PIPE_LAT; k++) vld_s[k] <= 1'b0;
		end else begin
			vld_s[1] <= start && !busy;
			for (int k = 2; k <= PIPE_LAT; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// ---------------------------------------------------------------- pipeline registers
	always_ff @(posedge clk) begin
		// Temperature.
		d_s1     <= d_c;
		rp_s[1]  <= sample.pressure_sample;
		rh_s[1]  <= sample.humidity_sample;
		dt2_s2   <= d_s1 * t2;
		dd_s2    <= d_s1 * d_s1;
		dt2_s3   <= dt2_s2;
		ddt3_s3  <= dd_s2 * t3;
		s_s4     <= s_c;
		temp_s[5] <= centi_c;
		fine_s[5] <= fine_c;
		x_s6     <= fine_s[5] - 26'sd76800;
		p_s6     <= fine_s[5] - 26'sd128000;

		// Humidity.
		h5x_s7   <= x_s6 * h5;
		h6x_s7   <= x_s6 * h6;
		h3x_s7   <= x_s6 * h3s;
		h6x_s8   <= h6x_s7;
		a_s8     <= (41'($signed({1'b0, rh_s[7]})) <<< 14) - (41'(h4) <<< 20) - 41'(h5x_s7);
		v5_s[8]  <= 36'(h3x_s7) + 36'sd67108864;
		ah2_s[9] <= a_s8 * h2;
		v6_s11   <= 45'(mul_p[MUL_H6V5] >>> 26) + 45'sd67108864;
		m_s14    <= 55'(mul_p[MUL_V5V6] >>> 26);
		v_s[17]  <= v_c;
		h1v_s18  <= v_s[17] * h1s;
		h_s21    <= 60'(v_s[20]) - 60'(mul_p[MUL_HV] >>> 39);
		hq_s[22] <= hq_c;

		// Pressure terms.
		pp_s7    <= p_s6 * p_s6;
		p5_s[7]  <= p_s6 * p5;
		p2_s[7]  <= p_s6 * p2;
		g_s[10]  <= 58'(mul_p[MUL_P6] >>> 11) + (58'(p5_s[9]) <<< 6) + (58'(p4) <<< 24);
		e_s10    <= 58'(mul_p[MUL_P3] >>> 11) + (58'(p2_s[9]) <<< 9);
		dv_s13   <= (44'(p1s) <<< 12) + 44'(mul_p[MUL_P1] >>> 32);
		n_s13    <= (59'($signed({1'b0, nb_c})) <<< 20) - 59'(g_s[12]);
		absn_s14 <= n_s13[58] ? 58'(-n_s13) : 58'(n_s13);
		neg_s[14] <= n_s13[58];
		inv_s[14] <= dv_s13 <= 0;
		dv_s[14]  <= dv_s13[42:0];
		num_s15   <= 71'(absn_s14) * 71'd6250;

		// A quotient that needs more than 45 bits saturates.
		ovf_s[16] <= {17'b0, num_s15[70:45]} >= dv_s[15];
		rem_s[16] <= {17'b0, num_s15[70:45]};
		low_s[16] <= num_s15[44:0];

		// Restoring division, one quotient bit per stage.
		for (int k = 17; k <= 61; k++) begin
			rem_s[k] <= fit[k] ? 43'(trial[k] - {1'b0, dv_s[k-1]}) : trial[k][42:0];
			low_s[k] <= {low_s[k-1][43:0], fit[k]};
			ovf_s[k] <= ovf_s[k-1];
		end

		q_s[62]  <= neg_s[61] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
		qp9_s63  <= q_s[62] * p9;
		qp8_s[63] <= q_s[62] * p8;
		t_s66    <= 72'(mul_p[MUL_Q9] >>> 39) + 72'(qp8_s[65] >>> 15) + (72'(p7) <<< 8);

		res_s67.temperature_centi <= temp_s[66];
		res_s67.pressure_q8       <= press_c;
		res_s67.humidity_q10      <= hq_s[66];
		res_s67.fine_temperature  <= 32'(fine_s[66]);
		res_s67.pressure_invalid  <= inv_s[66];

		// Delay lines.
		for (int k = 2; k <= 12; k++) rp_s[k] <= rp_s[k-1];
		for (int k = 2; k <= 7; k++) rh_s[k] <= rh_s[k-1];
		for (int k = 6; k <= 66; k++) begin
			temp_s[k] <= temp_s[k-1];
			fine_s[k] <= fine_s[k-1];
		end
		for (int k = 9; k <= 11; k++) v5_s[k] <= v5_s[k-1];
		for (int k = 10; k <= 14; k++) ah2_s[k] <= ah2_s[k-1];
		for (int k = 18; k <= 20; k++) v_s[k] <= v_s[k-1];
		for (int k = 23; k <= 66; k++) hq_s[k] <= hq_s[k-1];
		for (int k = 8; k <= 9; k++) begin
			p5_s[k] <= p5_s[k-1];
			p2_s[k] <= p2_s[k-1];
		end
		for (int k = 11; k <= 12; k++) g_s[k] <= g_s[k-1];
		for (int k = 15; k <= 60; k++) dv_s[k] <= dv_s[k-1];
		for (int k = 15; k <= 61; k++) neg_s[k] <= neg_s[k-1];
		for (int k = 15; k <= 66; k++) inv_s[k] <= inv_s[k-1];
		for (int k = 63; k <= 66; k++) q_s[k] <= q_s[k-1];
		for (int k = 64; k <= 65; k++) qp8_s[k] <= qp8_s[k-1];
	end

	assign result_valid = vld_s[PIPE_LAT];
	assign result       = res_s67;

	// ---------------------------------------------------------------- assertions
	`ASSERT_DELAY(a_latency, clk, arst_n, start && !busy, PIPE_LAT, result_valid)
	`ASSERT_IMPL(a_invalid_min, clk, arst_n, result_valid && result.pressure_invalid, result.pressure_q8 == P_MIN)
	`ASSERT_IMPL(a_range, clk, arst_n, result_valid, (result.humidity_q10 <= HUM_MAX) && (result.pressure_q8 >= P_MIN) && (result.pressure_q8 <= P_MAX))
	`ASSERT_NEXT(a_no_extra, clk, arst_n, !vld_s[PIPE_LAT-1], !result_valid)

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the environmental sensor compensation pipeline.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import esc_pkg::*;

	typedef logic signed [127:0] wide_t;
	typedef struct {
		sample_t smp;
		bit      typed;
		result_t want;
	} vector_t;

	localparam longint LIM62 = longint'(1) <<< 62;
	localparam longint LIM44 = longint'(1) <<< 44;
	localparam result_t IDLE_RESULT = '{temperature_centi: 15'sd0, pressure_q8: P_MIN,
		humidity_q10: 17'd0, fine_temperature: 32'sd0, pressure_invalid: 1'b1};

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	sample_t             sample;
	logic                result_valid;
	result_t             result;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	logic [63:0] coeff [NUM_REGS];
	result_t     pending_results [$];
	vector_t     vectors [$];
	int          mismatches;
	int          sent_count;
	int          checked_count;
	int          setting_count;

	env_sensor_compensation dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sample(sample),
		.result_valid(result_valid), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end

	// floor(a*b / 2^s) with the magnitude saturated to lim.
	function automatic longint mul_floor(longint a, longint b, int s, longint lim);
		wide_t pr;
		pr = a;
		pr = pr * b;
		pr = pr >>> s;
		if (pr > lim) pr = lim;
		if (pr < -lim) pr = -lim;
		return longint'(pr);
	endfunction

	// floor(6250*n / d) for d > 0, saturated to 2^44.
	function automatic longint div_floor(longint n, longint d);
		wide_t num, quo;
		num = n;
		num = num * 6250;
		quo = num / d;
		if (num < 0 && (num % d) != 0) quo = quo - 1;
		if (quo > LIM44) quo = LIM44;
		if (quo < -LIM44) quo = -LIM44;
		return longint'(quo);
	endfunction

	function automatic result_t compensate(sample_t smp);
		longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		longint h1, h2, h3, h4, h5, h6, rp, rt, rh;
		longint d, s, fine, centi, x, a, v5, v6, m, v, h, hq, p, g, e, dv, n, q, f;
		result_t r;
		t1 = coeff[0][15:0];
		t2 = longint'($signed(coeff[0][31:16]));
		t3 = longint'($signed(coeff[0][47:32]));
		p1 = coeff[1][15:0];
		p2 = longint'($signed(coeff[1][31:16]));
		p3 = longint'($signed(coeff[1][47:32]));
		p4 = longint'($signed(coeff[2][15:0]));
		p5 = longint'($signed(coeff[2][31:16]));
		p6 = longint'($signed(coeff[2][47:32]));
		p7 = longint'($signed(coeff[3][15:0]));
		p8 = longint'($signed(coeff[3][31:16]));
		p9 = longint'($signed(coeff[3][47:32]));
		h1 = coeff[4][7:0];
		h2 = longint'($signed(coeff[4][23:8]));
		h3 = coeff[4][31:24];
		h4 = longint'($signed(coeff[5][11:0]));
		h5 = longint'($signed(coeff[5][23:12]));
		h6 = longint'($signed(coeff[5][31:24]));
		rp = smp.pressure_sample;
		rt = smp.temperature_sample;
		rh = smp.humidity_sample;

		d = rt - longint'(16) * t1;
		s = d * t2 * longint'(1048576) + d * d * t3;
		fine = s / (longint'(1) <<< 34);
		centi = (s * longint'(5) + (longint'(1) <<< 41)) >>> 42;
		if (centi < -4000) centi = -4000;
		if (centi > 8500) centi = 8500;

		x = fine - longint'(76800);
		a = rh * longint'(16384) - h4 * longint'(1048576) - h5 * x;
		v5 = longint'(67108864) + h3 * x;
		v6 = longint'(67108864) + mul_floor(h6 * x, v5, 26, LIM62);
		m = mul_floor(v5, v6, 26, LIM62);
		v = mul_floor(a * h2, m, 36, LIM44);
		h = v - mul_floor(h1 * v, v, 39, LIM62);
		if (h < 0) h = 0;
		if (h > (longint'(100) <<< 20)) h = longint'(100) <<< 20;
		hq = (h + longint'(512)) >>> 10;

		p = fine - longint'(128000);
		g = mul_floor(p * p, p6, 11, LIM62) + p * p5 * longint'(64) + p4 * longint'(16777216);
		e = mul_floor(p * p, p3, 11, LIM62) + p2 * p * longint'(512);
		dv = p1 * longint'(4096) + mul_floor(p1, e, 32, LIM62);
		r.pressure_invalid = 1'b0;
		if (dv > 0) begin
			n = (longint'(1048576) - rp) * longint'(1048576) - g;
			q = div_floor(n, dv);
			f = q + ((mul_floor(q * p9, q, 39, LIM62) + ((q * p8) >>> 15)
				+ p7 * longint'(256)) >>> 4);
			if (f < longint'(P_MIN)) f = P_MIN;
			if (f > longint'(P_MAX)) f = P_MAX;
		end else begin
			f = P_MIN;
			r.pressure_invalid = 1'b1;
		end
		r.temperature_centi = centi[14:0];
		r.pressure_q8 = f[24:0];
		r.humidity_q10 = hq[16:0];
		r.fine_temperature = fine[31:0];
		return r;
	endfunction

	task automatic report(string field, longint got, longint want);
		mismatches++;
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0) begin
				report("unexpected transaction", 1, 0);
			end else begin
				want = pending_results.pop_front();
				checked_count++;
				if (result.temperature_centi !== want.temperature_centi)
					report("temperature_centi", result.temperature_centi, want.temperature_centi);
				if (result.pressure_q8 !== want.pressure_q8)
					report("pressure_q8", result.pressure_q8, want.pressure_q8);
				if (result.humidity_q10 !== want.humidity_q10)
					report("humidity_q10", result.humidity_q10, want.humidity_q10);
				if (result.fine_temperature !== want.fine_temperature)
					report("fine_temperature", result.fine_temperature, want.fine_temperature);
				if (result.pressure_invalid !== want.pressure_invalid)
					report("pressure_invalid", result.pressure_invalid, want.pressure_invalid);
			end
		end
	end

	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	task automatic write_coeff(int idx, logic [63:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= APB_AW'(idx * 8);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		if (idx < 4) coeff[idx] = value & 64'h0000_FFFF_FFFF_FFFF;
		else if (idx < NUM_REGS) coeff[idx] = value & 64'h0000_0000_FFFF_FFFF;
	endtask

	task automatic load_coeffs(logic [63:0] c0, logic [63:0] c1, logic [63:0] c2,
		logic [63:0] c3, logic [63:0] c4, logic [63:0] c5);
		drain();
		write_coeff(0, c0);
		write_coeff(1, c1);
		write_coeff(2, c2);
		write_coeff(3, c3);
		write_coeff(4, c4);
		write_coeff(5, c5);
		setting_count++;
	endtask

	task automatic load_typical();
		load_coeffs({16'd0, -16'sd1000, 16'sd26435, 16'd27504},
			{16'd0, 16'sd3024, -16'sd10685, 16'd36477},
			{16'd0, -16'sd7, 16'sd140, 16'sd2855},
			{16'd0, 16'sd6000, -16'sd14600, 16'sd15500},
			{32'd0, 8'd0, 16'sd362, 8'd75},
			{32'd0, 8'sd30, 12'sd50, 12'sd313});
	endtask

	// Start stays high across back-to-back transactions and drops only for a gap.
	task automatic send(sample_t smp, bit typed, result_t want);
		start <= 1'b1;
		sample <= smp;
		do @(posedge clk); while (busy);
		pending_results.push_back(typed ? want : compensate(smp));
		sent_count++;
	endtask

	function automatic vector_t row(logic [19:0] rp, logic [19:0] rt, logic [15:0] rh,
		bit typed);
		vector_t vr;
		vr.smp = '{pressure_sample: rp, temperature_sample: rt, humidity_sample: rh};
		vr.typed = typed;
		vr.want = IDLE_RESULT;
		return vr;
	endfunction

	function automatic sample_t random_sample();
		sample_t smp;
		if ($urandom_range(0, 99) < 70) begin
			smp.pressure_sample = 20'($urandom_range(150000, 700000));
			smp.temperature_sample = 20'($urandom_range(380000, 680000));
			smp.humidity_sample = 16'($urandom_range(15000, 50000));
		end else begin
			smp = sample_t'({$urandom, $urandom});
		end
		return smp;
	endfunction

	task automatic run_phase(int count, int idle_pct, bit hold_midway);
		int gap;
		for (int i = 0; i < count; i++) begin
			send(random_sample(), 1'b0, IDLE_RESULT);
			gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
			if (hold_midway && i == count / 2) begin
				start <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
			end else if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		start <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		mismatches = 0;
		sent_count = 0;
		checked_count = 0;
		setting_count = 1;
		foreach (coeff[i]) coeff[i] = '0;
		arst_n = 1'b0;
		start = 1'b0;
		sample = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Writes beyond the last register must leave the calibration untouched.
		write_coeff(6, 64'hFFFF_FFFF_FFFF_FFFF);
		write_coeff(7, 64'hFFFF_FFFF_FFFF_FFFF);

		// The first five rows run with all coefficients zero: the divisor is zero and every output is fixed.
		vectors.push_back(row(20'h00000, 20'h00000, 16'h0000, 1'b1));
		vectors.push_back(row(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b1));
		vectors.push_back(row(20'hAAAAA, 20'h55555, 16'hAAAA, 1'b1));
		vectors.push_back(row(20'h55555, 20'hAAAAA, 16'h5555, 1'b1));
		vectors.push_back(row(20'h00001, 20'h00001, 16'h0001, 1'b1));
		vectors.push_back(row(20'd415148, 20'd519888, 16'd30000, 1'b0));
		vectors.push_back(row(20'd415148, 20'h00000, 16'd30000, 1'b0));
		vectors.push_back(row(20'd415148, 20'hFFFFF, 16'd30000, 1'b0));
		vectors.push_back(row(20'h00000, 20'd519888, 16'd30000, 1'b0));
		vectors.push_back(row(20'hFFFFF, 20'd519888, 16'd30000, 1'b0));
		vectors.push_back(row(20'd415148, 20'd519888, 16'h0000, 1'b0));
		vectors.push_back(row(20'd415148, 20'd519888, 16'hFFFF, 1'b0));
		vectors.push_back(row(20'h00000, 20'h00000, 16'h0000, 1'b0));
		vectors.push_back(row(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0));
		vectors.push_back(row(20'd300000, 20'd600000, 16'd45000, 1'b0));

		foreach (vectors[i]) begin
			if (i > 0 && vectors[i - 1].typed && !vectors[i].typed) begin
				start <= 1'b0;
				load_typical();
			end
			send(vectors[i].smp, vectors[i].typed, vectors[i].want);
		end
		start <= 1'b0;
		@(posedge clk);

		run_phase(450, 0, 1'b0);
		load_coeffs(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		run_phase(150, 77, 1'b0);
		load_coeffs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
		run_phase(450, 77, 1'b1);
		load_coeffs({16'd0, 16'($urandom), 16'($urandom_range(20000, 30000)),
				16'($urandom_range(26000, 29000))},
			{16'd0, 16'($urandom), 16'($urandom), 16'($urandom_range(30000, 40000))},
			{16'd0, 16'($urandom), 16'($urandom), 16'($urandom)},
			{16'd0, 16'($urandom), 16'($urandom), 16'($urandom)},
			{32'd0, $urandom}, {32'd0, $urandom});
		run_phase(450, 23, 1'b0);
		load_typical();
		run_phase(300, 23, 1'b0);

		drain();
		$display("Sent %0d transactions and checked %0d results across %0d calibration sets,",
			sent_count, checked_count, setting_count);
		$display("with back-to-back, sparse and mixed start patterns.");
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== env_sensor_compensation.f =====
+incdir+hw/rtl
hw/rtl/esc_pkg.sv
hw/rtl/esc_mul.sv
hw/rtl/env_sensor_compensation.sv
tb/sv/tb_top.sv
